[rtl/stack_machine_alu_macros.svh]
// Assertion macros for the stack machine arithmetic unit.
// Used by the port checker; no other dependencies.
`ifndef STACK_MACHINE_ALU_MACROS_SVH
`define STACK_MACHINE_ALU_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define SMA_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define SMA_ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

[rtl/sma_pkg.sv]
// Shared types and codes for the stack machine arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps
package sma_pkg;
	localparam int unsigned WordW = 32;

	typedef enum logic [2:0] {
		ACT_PUSH = 3'd0, ACT_ADD = 3'd1, ACT_SUB = 3'd2, ACT_MUL = 3'd3,
		ACT_DIV = 3'd4, ACT_SQRT = 3'd5, ACT_OUT = 3'd6, ACT_UNK = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_UNDERFLOW = 3'd1, ST_DIV_ZERO = 3'd2,
		ST_NEG_ROOT = 3'd3, ST_OVERFLOW = 3'd4, ST_UNKNOWN = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		OP_MUL = 2'd0, OP_DIV = 2'd1, OP_SQRT = 2'd2
	} serop_t;

	// start request to the serial unit
	typedef struct packed {
		logic        start;
		serop_t      op;
		logic [31:0] lhs;
		logic [31:0] rhs;
	} ser_req_t;

	// completion from the serial unit
	typedef struct packed {
		logic        done;
		logic [31:0] result;
	} ser_rsp_t;
endpackage

[rtl/stack_machine_alu.sv]
// Stack machine arithmetic unit: top level with operand stack and sequencer.
// Depends on sma_pkg and sma_serial.
`timescale 1ns / 1ps
// One transaction in, one status transaction out. Push, add, sub, out, unknown
// and full-stack push pass through the stack read, execute and result states; a
// multiply, divide or root that fails its check also passes through the wait
// state. Multiply, divide and square root wait there on the bit-serial unit,
// which produces one result bit per cycle (two radicand bits per root step).
// One item is in work at a time; after its result is taken the block returns
// to idle before it accepts the next transaction.
module stack_machine_alu #(
	parameter int unsigned STACK_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [2:0] action, [34:3] push_value, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // [2:0] status, [3] out_valid, [35:4] out_value,
	                               // [40:36] depth, rest zero
);
	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001, S_RD = 5'b00010, S_EXE = 5'b00100,
		S_WAIT = 5'b01000, S_OUT = 5'b10000
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    cnt_q;
	sma_pkg::action_t act_q;
	logic [31:0]      pv_q, a_q, b_q;
	logic [31:0]      mem [STACK_DEPTH];
	logic [31:0]      rd_top, rd_sec;
	logic [2:0]       st_q;
	logic             ov_q;
	logic [31:0]      oval_q;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [31:0]      wr_data;
	sma_pkg::ser_req_t req;
	sma_pkg::ser_rsp_t rsp;

	sma_serial u_ser (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata  = {7'd0, 5'(cnt_q), oval_q, ov_q, st_q};

	// stack memory: registered reads of the top two entries
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_top <= mem[AW'(cnt_q - CW'(1))];
		rd_sec <= mem[AW'(cnt_q - CW'(2))];
	end

	always_comb begin
		req       = '0;
		req.lhs   = b_q;
		req.rhs   = a_q;
		req.op    = sma_pkg::OP_MUL;
		if (act_q == sma_pkg::ACT_DIV) req.op = sma_pkg::OP_DIV;
		if (act_q == sma_pkg::ACT_SQRT) begin
			req.op  = sma_pkg::OP_SQRT;
			req.lhs = a_q;
		end
		wr_en   = 1'b0;
		wr_addr = AW'(cnt_q - CW'(2));
		wr_data = rsp.result;
		case (state_q)
			S_EXE: begin
				case (act_q)
					sma_pkg::ACT_PUSH: begin
						wr_en = (cnt_q < CW'(STACK_DEPTH)); wr_addr = AW'(cnt_q); wr_data = pv_q;
					end
					sma_pkg::ACT_ADD: begin
						wr_en = (cnt_q >= CW'(2)); wr_data = b_q + a_q;
					end
					sma_pkg::ACT_SUB: begin
						wr_en = (cnt_q >= CW'(2)); wr_data = b_q - a_q;
					end
					sma_pkg::ACT_MUL: req.start = (cnt_q >= CW'(2));
					sma_pkg::ACT_DIV: req.start = (cnt_q >= CW'(2)) && (a_q != 32'd0);
					sma_pkg::ACT_SQRT: req.start = (cnt_q >= CW'(1)) && !a_q[31];
					default: ;
				endcase
			end
			S_WAIT: begin
				wr_en = rsp.done;
				if (act_q == sma_pkg::ACT_SQRT) wr_addr = AW'(cnt_q - CW'(1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			act_q   <= sma_pkg::ACT_PUSH;
			pv_q    <= '0;
			a_q     <= '0;
			b_q     <= '0;
			st_q    <= sma_pkg::ST_OK;
			ov_q    <= 1'b0;
			oval_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (s_tvalid) begin
					act_q   <= sma_pkg::action_t'(s_tdata[2:0]);
					pv_q    <= s_tdata[34:3];
					state_q <= S_RD;
				end
				S_RD: begin
					// top two entries were read at the accepting edge
					a_q <= rd_top; b_q <= rd_sec;
					state_q <= S_EXE;
				end
				S_EXE: begin
					state_q <= S_OUT;
					st_q   <= sma_pkg::ST_OK;
					ov_q   <= 1'b0;
					oval_q <= '0;
					case (act_q)
						sma_pkg::ACT_PUSH:
							if (cnt_q >= CW'(STACK_DEPTH)) st_q <= sma_pkg::ST_OVERFLOW;
							else cnt_q <= cnt_q + CW'(1);
						sma_pkg::ACT_ADD, sma_pkg::ACT_SUB:
							if (cnt_q < CW'(2)) st_q <= sma_pkg::ST_UNDERFLOW;
							else cnt_q <= cnt_q - CW'(1);
						sma_pkg::ACT_MUL, sma_pkg::ACT_DIV:
							state_q <= S_WAIT;
						sma_pkg::ACT_SQRT:
							state_q <= S_WAIT;
						sma_pkg::ACT_OUT:
							if (cnt_q < CW'(1)) st_q <= sma_pkg::ST_UNDERFLOW;
							else begin
								cnt_q <= cnt_q - CW'(1); ov_q <= 1'b1; oval_q <= a_q;
							end
						default: st_q <= sma_pkg::ST_UNKNOWN;
					endcase
				end
				S_WAIT: begin
					// error checks and serial completion
					if (act_q == sma_pkg::ACT_SQRT) begin
						if (cnt_q < CW'(1)) begin
							st_q <= sma_pkg::ST_UNDERFLOW; state_q <= S_OUT;
						end else if (a_q[31]) begin
							st_q <= sma_pkg::ST_NEG_ROOT; state_q <= S_OUT;
						end else if (rsp.done) state_q <= S_OUT;
					end else begin
						if (cnt_q < CW'(2)) begin
							st_q <= sma_pkg::ST_UNDERFLOW; state_q <= S_OUT;
						end else if (act_q == sma_pkg::ACT_DIV && a_q == 32'd0) begin
							st_q <= sma_pkg::ST_DIV_ZERO; state_q <= S_OUT;
						end else if (rsp.done) begin
							cnt_q <= cnt_q - CW'(1); state_q <= S_OUT;
						end
					end
				end
				S_OUT: if (m_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[rtl/sma_serial.sv]
// Bit-serial multiply, divide and square root unit, one result bit per cycle.
// Depends on sma_pkg.
`timescale 1ns / 1ps
module sma_serial (
	input  logic              clk,
	input  logic              arst_n,
	input  sma_pkg::ser_req_t req,
	output sma_pkg::ser_rsp_t rsp
);
	logic              busy_q;
	logic              done_q;
	sma_pkg::serop_t   op_q;
	logic [5:0]        cnt_q;
	logic [31:0]       acc_q;    // product / quotient / root
	logic [33:0]       rem_q;    // partial remainder
	logic [31:0]       sh_q;     // shifting operand (multiplier, dividend, radicand)
	logic [31:0]       opd_q;    // multiplicand or |divisor|
	logic              neg_q;

	logic [33:0] trial;
	logic [33:0] rem_sh;
	logic [31:0] lhs_abs, rhs_abs;
	logic [31:0] rsp_result_c;

	always_comb begin
		lhs_abs = req.lhs[31] ? (~req.lhs + 32'd1) : req.lhs;
		rhs_abs = req.rhs[31] ? (~req.rhs + 32'd1) : req.rhs;
		rem_sh  = '0;
		trial   = '0;
		case (op_q)
			sma_pkg::OP_DIV: begin
				rem_sh = {rem_q[32:0], sh_q[31]};
				trial  = rem_sh - {2'b00, opd_q};
			end
			sma_pkg::OP_SQRT: begin
				rem_sh = {rem_q[31:0], sh_q[31:30]};
				trial  = rem_sh - {acc_q, 2'b01};
			end
			default: begin
				rem_sh = '0;
				trial  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= sma_pkg::OP_MUL;
			cnt_q  <= '0;
			acc_q  <= '0;
			rem_q  <= '0;
			sh_q   <= '0;
			opd_q  <= '0;
			neg_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				acc_q  <= '0;
				rem_q  <= '0;
				case (req.op)
					sma_pkg::OP_MUL: begin
						cnt_q <= 6'd32; sh_q <= req.rhs; opd_q <= req.lhs; neg_q <= 1'b0;
					end
					sma_pkg::OP_DIV: begin
						cnt_q <= 6'd32; sh_q <= lhs_abs; opd_q <= rhs_abs;
						neg_q <= req.lhs[31] ^ req.rhs[31];
					end
					default: begin
						cnt_q <= 6'd16; sh_q <= req.lhs; opd_q <= '0; neg_q <= 1'b0;
					end
				endcase
			end else if (busy_q) begin
				// one step per cycle
				case (op_q)
					sma_pkg::OP_MUL: begin
						// LSB-first shift-add, low 32 bits only
						if (sh_q[0]) acc_q <= acc_q + opd_q;
						opd_q <= {opd_q[30:0], 1'b0};
						sh_q  <= {1'b0, sh_q[31:1]};
					end
					sma_pkg::OP_DIV: begin
						sh_q <= {sh_q[30:0], 1'b0};
						if (!trial[33]) begin
							rem_q <= trial; acc_q <= {acc_q[30:0], 1'b1};
						end else begin
							rem_q <= rem_sh; acc_q <= {acc_q[30:0], 1'b0};
						end
					end
					default: begin
						sh_q <= {sh_q[29:0], 2'b00};
						if (!trial[33]) begin
							rem_q <= trial; acc_q <= {acc_q[30:0], 1'b1};
						end else begin
							rem_q <= rem_sh; acc_q <= {acc_q[30:0], 1'b0};
						end
					end
				endcase
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// sign fix for the quotient; the last step's result is registered together with done
	always_comb begin
		rsp_result_c = neg_q ? (~acc_q + 32'd1) : acc_q;
	end
	assign rsp = '{done: done_q, result: rsp_result_c};
endmodule

[rtl/sma_checker.sv]
// Port checker for the stack machine arithmetic unit, bound to the top level.
// Depends on stack_machine_alu_macros.svh and sma_pkg.
`timescale 1ns / 1ps
`include "stack_machine_alu_macros.svh"
module sma_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);
	`SMA_ASSERT_IMP(a_one_in_flight, clk, arst_n, m_tvalid, !s_tready, "input taken during result")
	`SMA_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
	`SMA_ASSERT_IMP(a_flag, clk, arst_n, m_tvalid && m_tdata[3], m_tdata[2:0] == sma_pkg::ST_OK, "popped value with error")
	`SMA_ASSERT_IMP(a_zero, clk, arst_n, m_tvalid && !m_tdata[3], m_tdata[35:4] == 32'd0, "value without pop")
endmodule

bind stack_machine_alu sma_checker u_chk (.*);
